// ===== rtl/lltd_pkg.sv =====
`default_nettype none

package lltd_pkg;

   // Queue geometry
   localparam int NUM_QUEUES  = 4;
   localparam int QUEUE_DEPTH = 1024;
   localparam int TASK_BITS   = 16;

   localparam int QUEUE_BITS = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS  = QUEUE_BITS + PTR_BITS;
   localparam int MEM_WORDS  = 1 << ADDR_BITS;

   // Fixed field widths of the two channels
   localparam int TASK_ID_W   = 16;
   localparam int WORKER_W    = 2;
   localparam int QUSED_W     = 2;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 11;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // Command queue between the front and the back
   localparam int CMD_FIFO_DEPTH = 2;
   localparam int CMD_PTR_BITS   = $clog2(CMD_FIFO_DEPTH);
   localparam int CMD_CNT_BITS   = $clog2(CMD_FIFO_DEPTH + 1);

   // Operation codes carried in tuser
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // One decoded command as it travels from the front to the back
   typedef struct packed {
      logic                  is_pop;
      logic                  worker_ok;
      logic [QUEUE_BITS-1:0] queue;
      logic [WORKER_W-1:0]   worker;
      logic [TASK_BITS-1:0]  task_val;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/lltd_front.sv =====
`default_nettype none

module lltd_front
   import lltd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   output logic                        cmd_valid,
   input  wire logic                   cmd_ready,
   output cmd_type                     cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   logic [TASK_ID_W-1:0] task_id;
   logic [WORKER_W-1:0]  worker;

   assign task_id = req_tdata[TASK_ID_W-1:0];
   assign worker  = req_tdata[TASK_ID_W +: WORKER_W];

   // The stage takes a new item whenever it is empty or is being drained.
   assign req_tready = !valid_ff || cmd_ready;
   assign accept     = req_tvalid && req_tready;

   // Classify the item: operation, whether the worker names a real queue.
   always_comb begin
      cmd_in.is_pop    = (req_tuser == FUNC_POP);
      cmd_in.worker_ok = (int'(worker) < NUM_QUEUES);
      cmd_in.queue     = QUEUE_BITS'(worker);
      cmd_in.worker    = worker;
      cmd_in.task_val  = TASK_BITS'(task_id);
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

`default_nettype wire

// ===== rtl/lltd_cmd_fifo.sv =====
`default_nettype none

module lltd_cmd_fifo
   import lltd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire cmd_type in_cmd,
   output logic         out_valid,
   input  wire logic    out_ready,
   output cmd_type      out_cmd
);

   cmd_type                 entry_ff [CMD_FIFO_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_BITS-1:0] count_ff, count_in;
   logic                    push, pop;

   assign in_ready  = (count_ff != CMD_CNT_BITS'(CMD_FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_BITS'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_BITS'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lltd_back.sv =====
`default_nettype none

module lltd_back
   import lltd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    cmd_valid,
   output logic                         cmd_ready,
   input  wire cmd_type                 cmd,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata
);

   typedef enum logic [1:0] {
      ST_EXEC = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Per-queue pointers and occupancy counts
   logic [PTR_BITS-1:0]   head_ff  [NUM_QUEUES];
   logic [PTR_BITS-1:0]   head_in  [NUM_QUEUES];
   logic [PTR_BITS-1:0]   tail_ff  [NUM_QUEUES];
   logic [PTR_BITS-1:0]   tail_in  [NUM_QUEUES];
   logic [COUNT_BITS-1:0] count_ff [NUM_QUEUES];
   logic [COUNT_BITS-1:0] count_in [NUM_QUEUES];

   // Task store, one region per queue
   logic [TASK_BITS-1:0]  mem [MEM_WORDS];
   logic [TASK_BITS-1:0]  rdata_ff;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [ADDR_BITS-1:0]  mem_raddr;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [QUSED_W-1:0]    rsp_queue_ff, rsp_queue_in;
   logic [TASK_ID_W-1:0]  rsp_task_ff, rsp_task_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                  rsp_load;

   // Details of a pop waiting for its read data
   logic [QUSED_W-1:0]    pend_queue_ff, pend_queue_in;
   logic [OCC_W-1:0]      pend_occ_ff, pend_occ_in;

   logic                  rsp_free, take;
   logic [QUEUE_BITS-1:0] best, sel;
   logic [COUNT_BITS-1:0] best_count, sel_count;
   logic [PTR_BITS-1:0]   sel_head, sel_tail;

   // Least loaded queue: running minimum, the lowest index wins a tie.
   always_comb begin
      best       = '0;
      best_count = count_ff[0];
      for (int q = 1; q < NUM_QUEUES; q++) begin
         if (count_ff[q] < best_count) begin
            best       = QUEUE_BITS'(q);
            best_count = count_ff[q];
         end
      end
   end

   // One queue is touched per command.
   assign sel       = cmd.is_pop ? cmd.queue : best;
   assign sel_count = count_ff[sel];
   assign sel_head  = head_ff[sel];
   assign sel_tail  = tail_ff[sel];

   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign take      = (state_ff == ST_EXEC) && cmd_valid && rsp_free;
   assign cmd_ready = take;

   assign mem_waddr = {sel, sel_tail};
   assign mem_raddr = {sel, sel_head};

   // Command execution
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      rsp_load      = 1'b0;
      rsp_queue_in  = rsp_queue_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      pend_queue_in = pend_queue_ff;
      pend_occ_in   = pend_occ_ff;
      case (state_ff)
         ST_EXEC: begin
            if (take) begin
               if (!cmd.is_pop) begin
                  rsp_load     = 1'b1;
                  rsp_queue_in = QUSED_W'(best);
                  rsp_task_in  = '0;
                  if (best_count >= COUNT_BITS'(QUEUE_DEPTH)) begin
                     rsp_status_in = STATUS_FULL;
                     rsp_occ_in    = OCC_W'(best_count);
                  end else begin
                     mem_we         = 1'b1;
                     tail_in[best]  = (sel_tail == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                                      '0 : sel_tail + 1'b1;
                     count_in[best] = best_count + 1'b1;
                     rsp_status_in  = STATUS_OK;
                     rsp_occ_in     = OCC_W'(best_count + 1'b1);
                  end
               end else if (!cmd.worker_ok || sel_count == '0) begin
                  rsp_load      = 1'b1;
                  rsp_queue_in  = QUSED_W'(cmd.worker);
                  rsp_task_in   = '0;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_occ_in    = '0;
               end else begin
                  // The read is launched now; the data arrives next cycle.
                  head_in[sel]  = (sel_head == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                                  '0 : sel_head + 1'b1;
                  count_in[sel] = sel_count - 1'b1;
                  pend_queue_in = QUSED_W'(cmd.worker);
                  pend_occ_in   = OCC_W'(sel_count - 1'b1);
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            rsp_load      = 1'b1;
            rsp_queue_in  = pend_queue_ff;
            rsp_task_in   = TASK_ID_W'(rdata_ff);
            rsp_status_in = STATUS_OK;
            rsp_occ_in    = pend_occ_ff;
            state_in      = ST_EXEC;
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   // Result valid: set on a load, cleared when the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXEC;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q]  <= '0;
            tail_ff[q]  <= '0;
            count_ff[q] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_queue_ff  <= rsp_queue_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      pend_queue_ff <= pend_queue_in;
      pend_occ_ff   <= pend_occ_in;
   end

   // Task store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= cmd.task_val;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - QUSED_W - TASK_ID_W - STATUS_W - OCC_W){1'b0}},
                        rsp_occ_ff, rsp_status_ff, rsp_task_ff, rsp_queue_ff};

endmodule

`default_nettype wire

// ===== rtl/least_loaded_task_dispatcher_top.sv =====
// Least loaded task dispatcher.
// Items arrive on the req_ channel: req_tuser selects push (0) or pop (1),
// req_tdata carries the task id and, for a pop, the worker to pop from.
// Each item gives one result on the rsp_ channel: the queue used, the task
// popped, a status (ok, pop from an empty queue, push with all queues full)
// and the occupancy of that queue afterwards.
// A push goes to the queue with the smallest count, the lowest index on a tie.
// Items pass a decode register and a two-entry command queue before the
// execution unit, so the input keeps flowing while results wait.
// A push or a failed pop is executed in the EXEC state alone; a successful pop
// goes on to the READ state, as the task store's read data is registered.
// Reset empties every queue at once; the store itself is not cleared.
// When the receiver holds rsp_tready low, the result register holds its item,
// the execution unit waits, and the input stalls once the command queue fills.
`default_nettype none

module least_loaded_task_dispatcher_top
   import lltd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [15:0] task_id, [17:16] worker, [23:18] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] func
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [1:0] queue_used, [17:2] task_out, [19:18] status, [30:20] occupancy,
   // [31] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    back_valid, back_ready;
   cmd_type back_cmd;

   lltd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   lltd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   lltd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
